### rtl/scanline_rect_atlas_placer_assert.svh
// Assertion macros for the scanline rectangle atlas placer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SCANLINE_RECT_ATLAS_PLACER_ASSERT_SVH
`define SCANLINE_RECT_ATLAS_PLACER_ASSERT_SVH
`ifndef SYNTH
`define SRAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRAP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRAP_ASSERT_IMP(lbl, ante, cons)
`define SRAP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/srap_pkg.sv
// Shared types and constants of the scanline rectangle atlas placer.
// No dependencies.
`default_nettype none
package srap_pkg;
  localparam int MAX_ATLASES     = 8;
  localparam int RECTS_PER_ATLAS = 256;
  localparam int COORD_BITS      = 13;
  localparam int SUM_BITS        = COORD_BITS + 2;
  localparam int ATL_BITS        = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int ACNT_BITS       = $clog2(MAX_ATLASES + 1);
  localparam int RIDX_BITS       = (RECTS_PER_ATLAS > 1) ? $clog2(RECTS_PER_ATLAS) : 1;
  localparam int CNT_BITS        = $clog2(RECTS_PER_ATLAS + 1);
  localparam int ADDR_BITS       = ATL_BITS + RIDX_BITS;
  localparam int DEPTH           = MAX_ATLASES * RECTS_PER_ATLAS;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } rect_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   tx;
    logic [SUM_BITS-1:0]   ty;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } trial_t;
endpackage
`default_nettype wire

### rtl/srap_overlap.sv
// Overlap test between one stored rectangle and the trial area.
// Depends on srap_pkg.
`default_nettype none
module srap_overlap (
  input  srap_pkg::rect_t  entry_i,
  input  srap_pkg::trial_t trial_i,
  output logic             hit_o
);
  import srap_pkg::*;

  logic [SUM_BITS-1:0] ex, ey, ex_end, ey_end, tx_end, ty_end;

  always_comb begin
    ex     = SUM_BITS'(entry_i.x);
    ey     = SUM_BITS'(entry_i.y);
    ex_end = ex + SUM_BITS'(entry_i.w);
    ey_end = ey + SUM_BITS'(entry_i.h);
    tx_end = trial_i.tx + SUM_BITS'(trial_i.w);
    ty_end = trial_i.ty + SUM_BITS'(trial_i.h);
    hit_o  = (ex_end > trial_i.tx) && (ex < tx_end) &&
             (ey_end > trial_i.ty) && (ey < ty_end);
  end
endmodule
`default_nettype wire

### rtl/scanline_rect_atlas_placer.sv
// Scanline first-fit rectangle placer over up to eight atlases.
// Clear and reject results are registered directly from idle. A placement
// visits the atlases in order, skipping full ones; in each it tries trial
// positions, scans the stored entries against each and stores at the first fit.
// Memory entries are read one at a time. One item at a time: the next item is
// accepted once the result has been taken. Reset: atlases 4096 x 4096, all empty.
`default_nettype none
module scanline_rect_atlas_placer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [srap_pkg::COORD_BITS-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [srap_pkg::COORD_BITS-1:0] rect_width_i,
  input  logic [srap_pkg::COORD_BITS-1:0] rect_height_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [2:0]                      atlas_index_o,
  output logic [11:0]                     pos_x_o,
  output logic [11:0]                     pos_y_o
);
  import srap_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ATLAS = 7'b0000010,
    S_TRIAL = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_TEST  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [COORD_BITS-1:0] aw_q, ah_q;
  logic [CNT_BITS-1:0]   cnt_q [MAX_ATLASES];
  logic [ACNT_BITS-1:0]  a_q;
  logic [CNT_BITS-1:0]   i_q;
  logic [SUM_BITS-1:0]   tx_q, ty_q;
  logic [COORD_BITS-1:0] w_q, h_q, oh_q;
  rect_t                 mem [DEPTH];
  rect_t                 rd_q;
  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic [2:0]            idx_q;
  logic [11:0]           px_q, py_q;

  logic [ATL_BITS-1:0]   a_idx;
  logic [CNT_BITS-1:0]   cnt_cur;
  logic                  in_acc, out_acc, hit, fits, wraps;
  logic [SUM_BITS-1:0]   aw_ext, ah_ext, tx_next;
  trial_t                trial;

  assign a_idx   = a_q[ATL_BITS-1:0];
  assign cnt_cur = cnt_q[a_idx];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign aw_ext  = SUM_BITS'(aw_q);
  assign ah_ext  = SUM_BITS'(ah_q);
  assign fits    = (tx_q + SUM_BITS'(w_q) <= aw_ext) && (ty_q + SUM_BITS'(h_q) <= ah_ext);
  assign wraps   = (tx_q + SUM_BITS'(w_q)) > aw_ext;
  assign tx_next = tx_q + SUM_BITS'(rd_q.w);
  assign trial   = '{tx: tx_q, ty: ty_q, w: w_q, h: h_q};

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign atlas_index_o = idx_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;

  srap_overlap u_overlap (
    .entry_i (rd_q),
    .trial_i (trial),
    .hit_o   (hit)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i != MODE_CLEAR && rect_width_i <= aw_q && rect_height_i <= ah_q) begin
          state_d = S_ATLAS;
        end
      end
      S_ATLAS: begin
        if (a_q != ACNT_BITS'(MAX_ATLASES) &&
            cnt_cur != CNT_BITS'(RECTS_PER_ATLAS)) begin
          state_d = S_TRIAL;
        end else if (a_q == ACNT_BITS'(MAX_ATLASES)) begin
          state_d = S_IDLE;
        end
      end
      S_TRIAL: state_d = fits ? S_SCAN : S_ATLAS;
      S_SCAN:  state_d = (i_q == cnt_cur) ? S_WRITE : S_TEST;
      S_TEST:  state_d = hit ? S_STEP : S_SCAN;
      S_STEP:  state_d = S_TRIAL;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      aw_q        <= COORD_BITS'(4096);
      ah_q        <= COORD_BITS'(4096);
      out_valid_q <= 1'b0;
      a_q         <= '0;
      for (int k = 0; k < MAX_ATLASES; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_WIDTH) begin
          aw_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_HEIGHT) begin
          ah_q <= cfg_data_i;
        end
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          a_q <= '0;
          if (in_acc) begin
            if (mode_i == MODE_CLEAR) begin
              for (int k = 0; k < MAX_ATLASES; k++) begin
                cnt_q[k] <= '0;
              end
              out_valid_q <= 1'b1;
            end else if (rect_width_i > aw_q || rect_height_i > ah_q) begin
              out_valid_q <= 1'b1;
            end
          end
        end
        S_ATLAS: begin
          if (a_q == ACNT_BITS'(MAX_ATLASES)) begin
            out_valid_q <= 1'b1;
          end else if (cnt_cur == CNT_BITS'(RECTS_PER_ATLAS)) begin
            a_q <= a_q + 1'b1;
          end
        end
        S_TRIAL: begin
          if (!fits) begin
            a_q <= a_q + 1'b1;
          end
        end
        S_WRITE: begin
          cnt_q[a_idx] <= cnt_cur + 1'b1;
          out_valid_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        w_q <= rect_width_i;
        h_q <= rect_height_i;
        if (in_acc) begin
          idx_q <= '0;
          px_q  <= '0;
          py_q  <= '0;
          if (mode_i == MODE_CLEAR) begin
            status_q <= ST_PLACED;
          end else begin
            status_q <= ST_REJECT;
          end
        end
      end
      S_ATLAS: begin
        tx_q     <= '0;
        ty_q     <= '0;
        status_q <= ST_NOROOM;
      end
      S_TRIAL: i_q <= '0;
      S_SCAN:  rd_q <= mem[{a_idx, i_q[RIDX_BITS-1:0]}];
      S_TEST: begin
        if (hit) begin
          tx_q <= tx_next;
          oh_q <= rd_q.h;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      S_STEP: begin
        if (wraps) begin
          tx_q <= '0;
          ty_q <= ty_q + SUM_BITS'(oh_q);
        end
      end
      S_WRITE: begin
        mem[{a_idx, cnt_cur[RIDX_BITS-1:0]}] <=
          '{x: tx_q[COORD_BITS-1:0], y: ty_q[COORD_BITS-1:0], w: w_q, h: h_q};
        status_q <= ST_PLACED;
        idx_q    <= 3'(a_q);
        px_q     <= tx_q[11:0];
        py_q     <= ty_q[11:0];
      end
      default: ;
    endcase
  end

`include "scanline_rect_atlas_placer_assert.svh"

  `SRAP_ASSERT_NXT(a_write_result, state_q == S_WRITE, out_valid_q && status_q == ST_PLACED)
  `SRAP_ASSERT_NXT(a_accept_busy, in_acc, state_q != S_IDLE || out_valid_q)
  `SRAP_ASSERT_IMP(a_count_bound, state_q == S_SCAN, cnt_cur < CNT_BITS'(RECTS_PER_ATLAS))
  `SRAP_ASSERT_IMP(a_scan_index, state_q == S_SCAN || state_q == S_TEST, i_q <= cnt_cur)

endmodule
`default_nettype wire
